[design/sdu_pkg.sv]
// Shared result type and byte codes for the system exclusive sample dump unpacker.
// No dependencies.
package sdu_pkg;

  localparam logic [7:0] BYTE_START   = 8'hF0;
  localparam logic [7:0] BYTE_END     = 8'hF7;
  localparam logic [7:0] BYTE_MAKER   = 8'h41;
  localparam logic [7:0] BYTE_MODEL   = 8'h10;
  localparam logic [7:0] BYTE_COMMAND = 8'h12;
  localparam logic [7:0] ADDR_RESCAN  = 8'h01;

  localparam int SAMPLE_W = 16;

  // One result from the parser toward the output register
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
  } sdu_result_t;

endpackage

[design/sdu_parser.sv]
// Message parser: header match, address capture and sample pairing.
// Depends on sdu_pkg.
module sdu_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  output sdu_pkg::sdu_result_t result
);
  import sdu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEADER,
    ST_ADDRESS,
    ST_DATA
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  hist0_r, hist1_r, hist2_r;
  logic [7:0]  hist0_nxt, hist1_nxt, hist2_nxt;
  logic [1:0]  addr_cnt_r, addr_cnt_nxt;
  logic [7:0]  first_addr_r, first_addr_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [11:0] sum;

  // (hi << 5) + (lo >> 2); only the low 12 bits survive the shift by four
  assign sum = {high_r[6:0], 5'b0} + {6'b0, byte_in[7:2]};

  always_comb begin
    state_nxt      = state_r;
    hist0_nxt      = hist0_r;
    hist1_nxt      = hist1_r;
    hist2_nxt      = hist2_r;
    addr_cnt_nxt   = addr_cnt_r;
    first_addr_nxt = first_addr_r;
    phase_nxt      = phase_r;
    high_nxt       = high_r;
    result.valid   = 1'b0;
    result.sample  = {sum, 4'b0};
    if (accept) begin
      unique case (state_r)
        ST_IDLE: begin
          if (byte_in == BYTE_START) begin
            hist0_nxt = '0;
            hist1_nxt = '0;
            hist2_nxt = '0;
            state_nxt = ST_HEADER;
          end
        end
        ST_HEADER: begin
          if (byte_in == BYTE_END) begin
            state_nxt = ST_IDLE;
          end else begin
            hist0_nxt = hist1_r;
            hist1_nxt = hist2_r;
            hist2_nxt = byte_in;
            if (hist0_r == BYTE_MAKER && hist2_r == BYTE_MODEL &&
                byte_in == BYTE_COMMAND) begin
              addr_cnt_nxt = '0;
              state_nxt    = ST_ADDRESS;
            end
          end
        end
        ST_ADDRESS: begin
          if (addr_cnt_r == 2'd0) begin
            first_addr_nxt = byte_in;
          end
          if (addr_cnt_r == 2'd2) begin
            addr_cnt_nxt = '0;
            // first address byte was captured two items ago
            if (first_addr_r == ADDR_RESCAN) begin
              state_nxt = ST_HEADER;
            end else begin
              phase_nxt = 1'b0;
              state_nxt = ST_DATA;
            end
          end else begin
            addr_cnt_nxt = addr_cnt_r + 2'd1;
          end
        end
        ST_DATA: begin
          if (byte_in == BYTE_END) begin
            phase_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else if (!phase_r) begin
            high_nxt  = byte_in;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt    = 1'b0;
            result.valid = 1'b1;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hist0_r      <= '0;
      hist1_r      <= '0;
      hist2_r      <= '0;
      addr_cnt_r   <= '0;
      first_addr_r <= '0;
      phase_r      <= 1'b0;
      high_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      hist0_r      <= hist0_nxt;
      hist1_r      <= hist1_nxt;
      hist2_r      <= hist2_nxt;
      addr_cnt_r   <= addr_cnt_nxt;
      first_addr_r <= first_addr_nxt;
      phase_r      <= phase_nxt;
      high_r       <= high_nxt;
    end
  end

endmodule

[design/sdu_out_reg.sv]
// Result register: holds one sample until the downstream side takes it.
// Depends on sdu_pkg.
module sdu_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sdu_pkg::sdu_result_t        result,
  output logic                        full,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sdu_pkg::SAMPLE_W-1:0] out_sample
);
  import sdu_pkg::*;

  logic                valid_r, valid_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;

  assign full       = valid_r && out_stall;
  assign out_valid  = valid_r;
  assign out_sample = sample_r;

  always_comb begin
    valid_nxt  = valid_r;
    sample_nxt = sample_r;
    if (!full) begin
      // register drains or is empty: load whatever the parser gives
      valid_nxt  = result.valid;
      sample_nxt = result.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

endmodule

[design/sysex_sample_dump_unpacker.sv]
// Top level of the system exclusive sample dump unpacker.
// Depends on sdu_pkg, sdu_parser and sdu_out_reg.
//
// Takes one MIDI byte per item and emits one 16-bit sample for each
// (high, low) data byte pair of a sample data message. The parser state
// updates at acceptance and a sample lands in the result register on the
// same edge, so a byte can be accepted every cycle unless the input stalls.
// The input stalls only while the result register holds a sample that the
// downstream side is stalling; the sample for a low byte appears at the
// output in the cycle after that byte is accepted.
module sysex_sample_dump_unpacker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sdu_pkg::SAMPLE_W-1:0] out_sample
);
  import sdu_pkg::*;

  sdu_result_t result;
  logic        full;
  logic        in_accept;

  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  sdu_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .byte_in (in_byte),
    .result  (result)
  );

  sdu_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .result     (result),
    .full       (full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held sample");

  a_result_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> in_accept)
    else $error("sample produced without an accepted item");

  a_sample_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (result.valid && !full) |=> (out_valid && out_sample == $past(result.sample)))
    else $error("sample not loaded into result register");

endmodule

[test/tb_sysex_sample_dump_unpacker.sv]
// Testbench for sysex_sample_dump_unpacker: feeds MIDI byte streams, predicts
// the samples and checks every one in order. Depends on sdu_pkg and the RTL.
`timescale 1ns / 100ps

module tb_sysex_sample_dump_unpacker;
  import sdu_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_HEADER,
    SCAN_ADDRESS,
    SCAN_DATA
  } scan_mode_t;

  localparam int TARGET_ITEMS = 1600;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [7:0]          in_byte   = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_sample;

  sysex_sample_dump_unpacker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sample(out_sample)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0]          byte_feed_q[$];
  logic [SAMPLE_W-1:0] sample_q[$];
  int                  err_count    = 0;
  int                  bytes_fed    = 0;
  int                  samples_seen = 0;
  int                  holds_done   = 0;
  int                  gen_count    = 0;

  // Parser state mirror
  scan_mode_t  scan_mode  = SCAN_IDLE;
  logic [7:0]  hist[0:2]  = '{8'h00, 8'h00, 8'h00};
  logic [1:0]  addr_cnt   = 2'd0;
  logic [7:0]  addr_first = 8'h00;
  logic        low_phase  = 1'b0;
  logic [7:0]  hi_byte    = 8'h00;

  task automatic track_byte(input logic [7:0] b);
    logic        match;
    logic [31:0] wide;
    case (scan_mode)
      SCAN_IDLE: begin
        if (b == BYTE_START) begin
          hist      = '{8'h00, 8'h00, 8'h00};
          scan_mode = SCAN_HEADER;
        end
      end
      SCAN_HEADER: begin
        if (b == BYTE_END) begin
          scan_mode = SCAN_IDLE;
        end else begin
          match   = (hist[0] == BYTE_MAKER) && (hist[2] == BYTE_MODEL) &&
                    (b == BYTE_COMMAND);
          hist[0] = hist[1];
          hist[1] = hist[2];
          hist[2] = b;
          if (match) begin
            addr_cnt  = 2'd0;
            scan_mode = SCAN_ADDRESS;
          end
        end
      end
      SCAN_ADDRESS: begin
        if (addr_cnt == 2'd0) addr_first = b;
        addr_cnt = addr_cnt + 2'd1;
        if (addr_cnt == 2'd3) begin
          addr_cnt = 2'd0;
          if (addr_first == ADDR_RESCAN) begin
            scan_mode = SCAN_HEADER;
          end else begin
            low_phase = 1'b0;
            scan_mode = SCAN_DATA;
          end
        end
      end
      SCAN_DATA: begin
        // end of message drops any held high byte
        if (b == BYTE_END) begin
          low_phase = 1'b0;
          scan_mode = SCAN_IDLE;
        end else if (!low_phase) begin
          hi_byte   = b;
          low_phase = 1'b1;
        end else begin
          low_phase = 1'b0;
          wide = ((32'(hi_byte) << 5) + (32'(b) >> 2)) << 4;
          sample_q.push_back(wide[SAMPLE_W-1:0]);
        end
      end
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        track_byte(in_byte);
        bytes_fed++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_feed_q.size() > 0) begin
        in_valid <= 1'b1;
        in_byte  <= byte_feed_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches every so often, plus two long holds
  int   stall_mode = 0;
  int   mode_left  = 0;
  int   hold_left  = 0;
  int   cyc        = 0;
  logic stall_next;

  always @(posedge clk) begin
    if (rst_n) begin
      cyc++;
      if (out_valid && !out_stall) begin
        samples_seen++;
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample: expected none, actual %h", $time, out_sample);
          err_count++;
        end else if (out_sample !== sample_q[0]) begin
          $display("%0t: sample mismatch: expected %h, actual %h",
                   $time, sample_q[0], out_sample);
          err_count++;
          void'(sample_q.pop_front());
        end else begin
          void'(sample_q.pop_front());
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if ((holds_done == 0 && samples_seen >= 60) ||
                   (holds_done == 1 && samples_seen >= 250)) begin
        // hold off long enough for the result register to fill and block input
        hold_left  = LONG_HOLD;
        holds_done++;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ((cyc % 5) < 2);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  task automatic add_byte(input logic [7:0] b, input bit counted);
    byte_feed_q.push_back(b);
    if (counted) gen_count++;
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == BYTE_END) v = v ^ 8'h01;
    return v;
  endfunction

  task automatic add_header(input logic [7:0] a0);
    add_byte(BYTE_MAKER, 1'b1);
    add_byte(8'($urandom_range(0, 255)), 1'b1);
    add_byte(BYTE_MODEL, 1'b1);
    add_byte(BYTE_COMMAND, 1'b1);
    add_byte(a0, 1'b1);
    add_byte(8'($urandom_range(0, 255)), 1'b1);
    add_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int         kind;
    int         npairs;
    logic [7:0] a0;
    logic [7:0] directed[$];

    // idle bytes are ignored; then a data message with extreme bytes, a start
    // byte taken as data and an end byte dropping a held high byte
    directed = '{8'h00, 8'hFF,
                 BYTE_START, BYTE_MAKER, 8'h00, BYTE_MODEL, BYTE_COMMAND, 8'h02, 8'h00, 8'h00,
                 8'hFF, 8'hFF, 8'h00, 8'h00, BYTE_START, 8'h80, 8'h12, BYTE_END,
                 // rescan address carrying an end byte, start byte inside header,
                 // end byte in header scan
                 BYTE_START, BYTE_MAKER, 8'h7F, BYTE_MODEL, BYTE_COMMAND, ADDR_RESCAN,
                 BYTE_END, 8'h00, BYTE_START, BYTE_END};
    foreach (directed[i]) add_byte(directed[i], 1'b1);

    while (gen_count < TARGET_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        add_byte(BYTE_START, 1'b1);
        if (kind == 6) add_header(ADDR_RESCAN);
        repeat ($urandom_range(0, 3)) add_byte(data_byte(), 1'b1);
        a0 = 8'($urandom_range(0, 255));
        if (a0 == ADDR_RESCAN) a0 = 8'h00;
        add_header(a0);
        npairs = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        repeat (2 * npairs) add_byte(data_byte(), 1'b1);
        if ($urandom_range(0, 3) == 0) add_byte(data_byte(), 1'b1);
        add_byte(BYTE_END, 1'b1);
      end else if (kind == 7) begin
        // broken message: partial header then end
        add_byte(BYTE_START, 1'b1);
        if ($urandom_range(0, 1)) begin
          add_byte(BYTE_MAKER, 1'b1);
          add_byte(8'($urandom_range(0, 255)), 1'b1);
          add_byte(BYTE_MODEL, 1'b1);
        end
        repeat ($urandom_range(0, 5)) add_byte(data_byte(), 1'b1);
        add_byte(BYTE_END, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (byte_feed_q.size() != 0 || in_valid || sample_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sample_q.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, sample_q.size());
      err_count++;
    end
    $display("Fed %0d bytes of sample dump traffic, checked %0d samples", bytes_fed,
             samples_seen);
    $display("Output held off for %0d long stretches under random stalls", holds_done);
    if (err_count == 0) begin
      $display("sysex_sample_dump_unpacker: match");
    end else begin
      $display("sysex_sample_dump_unpacker: mismatch");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("%0t: timeout", $time);
    $display("sysex_sample_dump_unpacker: mismatch");
    $finish;
  end

endmodule
